// File: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file of the capture window gate
// no dependencies; clock i_clk and reset i_rst_n are assumed in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// consequent must hold at the edge after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tcwg_pkg.sv
// shared types, register indexes and constants of the capture window gate
// no dependencies
package tcwg_pkg;

    localparam int DEF_TIME_BITS    = 48;
    localparam int DEF_PAYLOAD_BITS = 64;

    // period and tolerance registers, and their sum
    localparam int REG_BITS   = 24;
    localparam int LIMIT_BITS = REG_BITS + 1;

    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_START  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_END    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLE_PERIOD = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAP_TOLERANCE = 2'd3;

    localparam logic [REG_BITS-1:0] RST_SAMPLE_PERIOD = 24'd1000;
    localparam logic [REG_BITS-1:0] RST_GAP_TOLERANCE = 24'd100;

    // status sideband: captured, phase, finished, gap_warning, zero pad
    localparam int USER_BITS = 8;

    typedef enum logic [2:0] {
        PH_CHECK   = 3'd0,
        PH_WAIT    = 3'd1,
        PH_GATHER  = 3'd2,
        PH_SUCCESS = 3'd3,
        PH_LATE    = 3'd4,
        PH_DROPPED = 3'd5
    } t_phase;

    typedef struct packed {
        logic   gap_warning;
        logic   finished;
        t_phase phase;
        logic   captured;
    } t_status;

    function automatic logic phase_done(input t_phase ph);
        return (ph == PH_SUCCESS) || (ph == PH_LATE) || (ph == PH_DROPPED);
    endfunction

endpackage

// File: rtl/timed_capture_window_gate.sv
// top level of the capture window gate: stream ports, input and result registers
// depends on tcwg_pkg, tcwg_cfg_regs, tcwg_gate_core and assert_macros.svh
// usage
//   write window_start, window_end, sample_period and gap_tolerance on the
//   config port while the block is idle (index 0..3, one write per cycle)
//   feed timestamped samples on the slave stream; one result beat comes out on
//   the master stream for every input beat, in order
//   the result carries the payload in tdata (zero when not captured) and the
//   status in tuser: captured, phase, finished, gap warning
// timing
//   one beat per cycle sustained while m_axis_tready is high; each beat goes through
//   the input register, then the single-pass decision into the result register,
//   and a stall can hold it in the input register
//   the decision for a beat depends on the phase and last time left by the
//   previous beat, which is held in the core and updated in the same cycle
// reset
//   synchronous, active low: config returns to defaults, phase to check, no
//   previous sample, both registers empty; a new window needs a reset
// stall
//   when m_axis_tready is low the result register holds, the input register
//   holds one more beat, then s_axis_tready drops until the result is taken
`include "assert_macros.svh"

module timed_capture_window_gate #(
    parameter int TIME_BITS    = tcwg_pkg::DEF_TIME_BITS,
    parameter int PAYLOAD_BITS = tcwg_pkg::DEF_PAYLOAD_BITS,
    parameter int CFG_BITS     = (TIME_BITS > tcwg_pkg::REG_BITS) ? TIME_BITS
                                                                   : tcwg_pkg::REG_BITS,
    parameter int IN_BITS      = ((TIME_BITS + PAYLOAD_BITS + 7) / 8) * 8,
    parameter int OUT_BITS     = ((PAYLOAD_BITS + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [tcwg_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]               i_cfg_data,
    // sample stream in
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [IN_BITS-1:0]                s_axis_tdata,  // sample_time, sample_payload
    // result stream out
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [OUT_BITS-1:0]               m_axis_tdata,  // captured_payload
    output logic [tcwg_pkg::USER_BITS-1:0]    m_axis_tuser   // captured, phase[2:0],
                                                             // finished, gap_warning
);

    logic [TIME_BITS-1:0]          w_window_start;
    logic [TIME_BITS-1:0]          w_window_end;
    logic [tcwg_pkg::REG_BITS-1:0] w_sample_period;
    logic [tcwg_pkg::REG_BITS-1:0] w_gap_tolerance;

    // input register
    logic                    r_in_valid;
    logic [TIME_BITS-1:0]    r_in_time;
    logic [PAYLOAD_BITS-1:0] r_in_payload;

    // result register
    logic                    r_out_valid;
    logic [PAYLOAD_BITS-1:0] r_out_payload;
    tcwg_pkg::t_status       r_out_status;

    logic              w_advance;
    logic              w_in_fire;
    tcwg_pkg::t_status w_status;
    tcwg_pkg::t_phase  w_state_phase;

    tcwg_cfg_regs #(
        .TIME_BITS (TIME_BITS),
        .CFG_BITS  (CFG_BITS)
    ) u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_window_start  (w_window_start),
        .o_window_end    (w_window_end),
        .o_sample_period (w_sample_period),
        .o_gap_tolerance (w_gap_tolerance)
    );

    // a held beat moves on when the result register is empty or being drained
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    tcwg_gate_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (w_advance),
        .i_time          (r_in_time),
        .i_window_start  (w_window_start),
        .i_window_end    (w_window_end),
        .i_sample_period (w_sample_period),
        .i_gap_tolerance (w_gap_tolerance),
        .o_status        (w_status),
        .o_state_phase   (w_state_phase)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_time    <= s_axis_tdata[TIME_BITS-1:0];
            r_in_payload <= s_axis_tdata[TIME_BITS +: PAYLOAD_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_payload <= w_status.captured ? r_in_payload : '0;
            r_out_status  <= w_status;
        end
    end

    always_comb begin
        m_axis_tvalid                     = r_out_valid;
        m_axis_tdata                      = '0;
        m_axis_tdata[PAYLOAD_BITS-1:0]    = r_out_payload;
        m_axis_tuser                      = '0;
        m_axis_tuser[$bits(r_out_status)-1:0] = r_out_status;
    end

    // a capture only ever happens inside the gathering phase
    `ASSERT_ALWAYS(a_cap_in_gather,
        !r_out_valid || !r_out_status.captured || r_out_status.phase == tcwg_pkg::PH_GATHER,
        "capture reported outside gathering")

    // payload is zeroed whenever the beat was not captured
    `ASSERT_ALWAYS(a_uncaptured_zero,
        !r_out_valid || r_out_status.captured || r_out_payload == '0,
        "uncaptured beat carries payload")

    // a finished capture never leaves its final phase
    `ASSERT_NEXT(a_final_sticky,
        tcwg_pkg::phase_done(w_state_phase),
        w_state_phase == $past(w_state_phase),
        "finished phase changed")

    // input is only blocked while both registers hold a beat
    `ASSERT_ALWAYS(a_stall_full,
        s_axis_tready || (r_in_valid && r_out_valid),
        "input stalled with room in the pipe")

endmodule

// File: rtl/tcwg_cfg_regs.sv
// configuration register file: window bounds, sample period, gap tolerance
// depends on tcwg_pkg
module tcwg_cfg_regs #(
    parameter int TIME_BITS = tcwg_pkg::DEF_TIME_BITS,
    parameter int CFG_BITS  = (TIME_BITS > tcwg_pkg::REG_BITS) ? TIME_BITS
                                                                : tcwg_pkg::REG_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tcwg_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]               i_cfg_data,
    output logic [TIME_BITS-1:0]              o_window_start,
    output logic [TIME_BITS-1:0]              o_window_end,
    output logic [tcwg_pkg::REG_BITS-1:0]     o_sample_period,
    output logic [tcwg_pkg::REG_BITS-1:0]     o_gap_tolerance
);

    logic [TIME_BITS-1:0]          r_window_start;
    logic [TIME_BITS-1:0]          r_window_end;
    logic [tcwg_pkg::REG_BITS-1:0] r_sample_period;
    logic [tcwg_pkg::REG_BITS-1:0] r_gap_tolerance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_start  <= '0;
            r_window_end    <= '0;
            r_sample_period <= tcwg_pkg::RST_SAMPLE_PERIOD;
            r_gap_tolerance <= tcwg_pkg::RST_GAP_TOLERANCE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tcwg_pkg::REG_WINDOW_START:  r_window_start  <= i_cfg_data[TIME_BITS-1:0];
                tcwg_pkg::REG_WINDOW_END:    r_window_end    <= i_cfg_data[TIME_BITS-1:0];
                tcwg_pkg::REG_SAMPLE_PERIOD: begin
                    r_sample_period <= i_cfg_data[tcwg_pkg::REG_BITS-1:0];
                end
                tcwg_pkg::REG_GAP_TOLERANCE: begin
                    r_gap_tolerance <= i_cfg_data[tcwg_pkg::REG_BITS-1:0];
                end
                default: ;
            endcase
        end
    end

    assign o_window_start  = r_window_start;
    assign o_window_end    = r_window_end;
    assign o_sample_period = r_sample_period;
    assign o_gap_tolerance = r_gap_tolerance;

endmodule

// File: rtl/tcwg_gate_core.sv
// capture state and per-beat decision: gap check, phase update, capture flag
// depends on tcwg_pkg
module tcwg_gate_core #(
    parameter int TIME_BITS = tcwg_pkg::DEF_TIME_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic [TIME_BITS-1:0]          i_time,
    input  logic [TIME_BITS-1:0]          i_window_start,
    input  logic [TIME_BITS-1:0]          i_window_end,
    input  logic [tcwg_pkg::REG_BITS-1:0] i_sample_period,
    input  logic [tcwg_pkg::REG_BITS-1:0] i_gap_tolerance,
    output tcwg_pkg::t_status             o_status,
    output tcwg_pkg::t_phase              o_state_phase
);

    localparam int CMP_BITS = (TIME_BITS > tcwg_pkg::LIMIT_BITS) ? TIME_BITS
                                                                 : tcwg_pkg::LIMIT_BITS;

    tcwg_pkg::t_phase r_phase;
    tcwg_pkg::t_phase n_phase;
    logic [TIME_BITS-1:0] r_last_time;
    logic                 r_have_last;

    logic [TIME_BITS-1:0]            w_diff;
    logic [tcwg_pkg::LIMIT_BITS-1:0] w_limit;
    logic                            w_gap;
    logic                            w_warn;
    logic                            w_cap;

    always_comb begin
        // going back in time counts as no gap
        w_diff  = (i_time >= r_last_time) ? (i_time - r_last_time) : '0;
        w_limit = tcwg_pkg::LIMIT_BITS'(i_sample_period) +
                  tcwg_pkg::LIMIT_BITS'(i_gap_tolerance);
        w_gap   = r_have_last && (CMP_BITS'(w_diff) > CMP_BITS'(w_limit));

        n_phase = r_phase;
        w_warn  = 1'b0;
        w_cap   = 1'b0;

        if (w_gap) begin
            if (r_phase == tcwg_pkg::PH_GATHER) begin
                n_phase = tcwg_pkg::PH_DROPPED;
            end else begin
                w_warn = 1'b1;
            end
        end

        unique case (n_phase)
            tcwg_pkg::PH_CHECK: begin
                n_phase = (i_time >= i_window_start) ? tcwg_pkg::PH_LATE
                                                     : tcwg_pkg::PH_WAIT;
            end
            tcwg_pkg::PH_WAIT: begin
                if (i_time >= i_window_start) begin
                    n_phase = (i_time < i_window_end) ? tcwg_pkg::PH_GATHER
                                                      : tcwg_pkg::PH_SUCCESS;
                    w_cap   = (i_time < i_window_end);
                end
            end
            tcwg_pkg::PH_GATHER: begin
                if (i_time < i_window_end) begin
                    w_cap = 1'b1;
                end else begin
                    n_phase = tcwg_pkg::PH_SUCCESS;
                end
            end
            default: ;
        endcase

        o_status.captured    = w_cap;
        o_status.phase       = n_phase;
        o_status.finished    = tcwg_pkg::phase_done(n_phase);
        o_status.gap_warning = w_warn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= tcwg_pkg::PH_CHECK;
            r_last_time <= '0;
            r_have_last <= 1'b0;
        end else if (i_advance) begin
            r_phase     <= n_phase;
            r_last_time <= i_time;
            r_have_last <= 1'b1;
        end
    end

    assign o_state_phase = r_phase;

endmodule
